// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/tftprx_pkg.sv =====
// ----------------------------------------------------------------------------
// tftprx_pkg
// Types and constants shared by the TFTP receive sequencer modules.
// ----------------------------------------------------------------------------
package tftprx_pkg;

    localparam logic [15:0] BLOCK_BYTES = 16'd512;
    localparam logic [15:0] HDR_BYTES   = 16'd4;
    localparam logic [15:0] OPC_DATA    = 16'd3;
    localparam logic [15:0] OPC_ERROR   = 16'd5;

    localparam logic [15:0] OWN_PORT_RST    = 16'd69;
    localparam logic [15:0] PEER_PORT_RST   = 16'd69;
    localparam logic [31:0] SERVER_ADDR_RST = 32'd0;
    localparam logic [3:0]  RETRY_LIMIT_RST = 4'd10;
    localparam logic [15:0] EXP_BLOCK_RST   = 16'd1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_RUN    = 3'd1,
        PH_DONE   = 3'd2,
        PH_SHORT  = 3'd3,
        PH_SRVERR = 3'd4,
        PH_BADOP  = 3'd5,
        PH_RETRY  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_RRQ  = 2'd1,
        ACT_ACK  = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OWN_PORT    = 2'd0,
        REG_PEER_PORT   = 2'd1,
        REG_SERVER_ADDR = 2'd2,
        REG_RETRY_LIMIT = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] own_port;
        logic [15:0] peer_port;
        logic [31:0] server_address;
        logic [3:0]  retry_limit;
    } cfg_t;

    // classified word handed from front to back
    typedef struct packed {
        logic        is_start;
        logic        hit;        // port and address match
        logic        short_pkt;
        logic        opc_err;
        logic        opc_data;
        logic [15:0] reply_port;
        logic [15:0] pay_len;
        logic        pay_small;  // payload below a full block
        logic [15:0] blk;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic valid;
    } qstat_t;

    typedef struct packed {
        action_t     action;
        logic [15:0] ack_port;
        logic [15:0] ack_block;
        logic        payload_write;
        logic [15:0] payload_len;
        phase_t      status;
    } res_t;

endpackage

// ===== hw/rtl/tftprx_queue.sv =====
// ----------------------------------------------------------------------------
// tftprx_queue
// Short FIFO of classified words between front and back.
// ----------------------------------------------------------------------------
module tftprx_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tftprx_pkg::cmd_t   push_cmd,
    input  logic               pop,
    output tftprx_pkg::cmd_t   head_cmd,
    output tftprx_pkg::qstat_t stat
);
    import tftprx_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign stat.full  = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.valid = (cnt_reg != '0);

endmodule

// ===== hw/rtl/tftprx_front.sv =====
// ----------------------------------------------------------------------------
// tftprx_front
// Input word acceptance and header classification.
// ----------------------------------------------------------------------------
module tftprx_front (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [tftprx_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic               s_tuser,
    input  tftprx_pkg::cfg_t   cfg,
    input  tftprx_pkg::qstat_t qstat,
    output logic               push,
    output tftprx_pkg::cmd_t   push_cmd
);
    import tftprx_pkg::*;

    logic [15:0] dst_udp_port;
    logic [31:0] src_address;
    logic [15:0] src_udp_port;
    logic [15:0] pkt_length;
    logic [15:0] pkt_opcode;
    logic [15:0] block_number;

    assign dst_udp_port = s_tdata[15:0];
    assign src_address  = s_tdata[47:16];
    assign src_udp_port = s_tdata[63:48];
    assign pkt_length   = s_tdata[79:64];
    assign pkt_opcode   = s_tdata[95:80];
    assign block_number = s_tdata[111:96];

    assign s_tready = !qstat.full;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_cmd.is_start   = !s_tuser;
        push_cmd.hit        = (dst_udp_port == cfg.own_port)
                           && (src_address == cfg.server_address);
        push_cmd.short_pkt  = (pkt_length < HDR_BYTES);
        push_cmd.opc_err    = (pkt_opcode == OPC_ERROR);
        push_cmd.opc_data   = (pkt_opcode == OPC_DATA);
        push_cmd.reply_port = src_udp_port;
        push_cmd.pay_len    = pkt_length - HDR_BYTES;
        push_cmd.pay_small  = (push_cmd.pay_len < BLOCK_BYTES);
        push_cmd.blk        = block_number;
    end

endmodule

// ===== hw/rtl/tftprx_back.sv =====
// ----------------------------------------------------------------------------
// tftprx_back
// Transfer state, per-word decision and registered result.
// ----------------------------------------------------------------------------
module tftprx_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tftprx_pkg::cfg_t   cfg,
    input  tftprx_pkg::qstat_t qstat,
    input  tftprx_pkg::cmd_t   cmd,
    output logic               pop,
    input  logic               m_tready,
    output logic               m_tvalid,
    output tftprx_pkg::res_t   res
);
    import tftprx_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] exp_blk_reg, exp_blk_next;
    logic [3:0]  retry_reg, retry_next;
    logic        out_valid_reg;
    res_t        out_reg, out_next;

    assign pop = qstat.valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        phase_next   = phase_reg;
        exp_blk_next = exp_blk_reg;
        retry_next   = retry_reg;
        out_next     = '0;
        if (cmd.is_start)
        begin
            exp_blk_next      = EXP_BLOCK_RST;
            retry_next        = '0;
            phase_next        = PH_RUN;
            out_next.action   = ACT_RRQ;
            out_next.ack_port = cfg.peer_port;
        end
        else if (phase_reg == PH_RUN && cmd.hit)
        begin
            priority if (cmd.short_pkt)
            begin
                phase_next = PH_SHORT;
            end
            else if (cmd.opc_err)
            begin
                phase_next = PH_SRVERR;
            end
            else if (!cmd.opc_data)
            begin
                phase_next = PH_BADOP;
            end
            else if (cmd.blk != exp_blk_reg)
            begin
                if (retry_reg >= cfg.retry_limit)
                begin
                    phase_next = PH_RETRY;
                end
                else
                begin
                    // older block: re-ack what we still wait for
                    if (cmd.blk < exp_blk_reg)
                    begin
                        out_next.action    = ACT_ACK;
                        out_next.ack_port  = cfg.peer_port;
                        out_next.ack_block = exp_blk_reg;
                    end
                    retry_next = retry_reg + 1'b1;
                end
            end
            else
            begin
                retry_next             = '0;
                out_next.payload_write = 1'b1;
                out_next.payload_len   = cmd.pay_len;
                out_next.action        = ACT_ACK;
                out_next.ack_port      = cmd.reply_port;
                out_next.ack_block     = cmd.blk;
                exp_blk_next           = exp_blk_reg + 1'b1;
                if (cmd.pay_small)
                begin
                    phase_next = PH_DONE;
                end
            end
        end
        out_next.status = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            exp_blk_reg   <= EXP_BLOCK_RST;
            retry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg     <= phase_next;
                exp_blk_reg   <= exp_blk_next;
                retry_reg     <= retry_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign res      = out_reg;

endmodule

// ===== hw/rtl/tftp_receive_block_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tftp_receive_block_sequencer_unit
// Receive-side TFTP read transfer sequencer, header decisions only.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one word per start command (tuser 0) or received packet
//     header (tuser 1). m_* stream: exactly one result word per input word,
//     in order, carrying the action, ack fields, payload write and status.
//   cfg_we/cfg_index/cfg_data: register writes, taken at any edge with
//     cfg_we high; write only while no words are in flight.
//   Path: an accepted word passes the queue and then the result register to
//     m_* (two register stages: the queue and the result register).
//   Throughput: one word per cycle while m_tready does not stall the result,
//     set by the combinational decision in the back part.
//   Stall: while m_tready is low the result register holds its word, the
//     back part stops popping, and the two-entry queue absorbs input until
//     full, at which point s_tready drops.
//   Reset: queue empty, no result pending, status idle, expected block 1,
//     retries 0, registers at their documented defaults.
// ----------------------------------------------------------------------------
module tftp_receive_block_sequencer_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [15:0] dst_udp_port, [47:16] src_address, [63:48] src_udp_port,
    // [79:64] pkt_length, [95:80] pkt_opcode, [111:96] block_number
    input  logic [tftprx_pkg::IN_DATA_W-1:0]       s_tdata,
    // [0] op
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [15:0] ack_port, [31:16] ack_block, [32] payload_write,
    // [48:33] payload_len, [51:49] status, [55:52] zero
    output logic [tftprx_pkg::OUT_DATA_W-1:0]      m_tdata,
    // [1:0] action
    output logic [1:0]                             m_tuser,
    input  logic                                   cfg_we,
    input  logic [tftprx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tftprx_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tftprx_pkg::*;

    cfg_t   cfg_reg;
    qstat_t qstat;
    cmd_t   push_cmd;
    cmd_t   head_cmd;
    logic   push;
    logic   pop;
    res_t   res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_port       <= OWN_PORT_RST;
            cfg_reg.peer_port      <= PEER_PORT_RST;
            cfg_reg.server_address <= SERVER_ADDR_RST;
            cfg_reg.retry_limit    <= RETRY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_OWN_PORT:    cfg_reg.own_port       <= cfg_data[15:0];
                REG_PEER_PORT:   cfg_reg.peer_port      <= cfg_data[15:0];
                REG_SERVER_ADDR: cfg_reg.server_address <= cfg_data[31:0];
                REG_RETRY_LIMIT: cfg_reg.retry_limit    <= cfg_data[3:0];
                default:         cfg_reg.retry_limit    <= cfg_reg.retry_limit;
            endcase
        end
    end

    // front: accept and classify
    tftprx_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // decoupling queue
    tftprx_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (qstat)
    );

    // back: transfer state and result register
    tftprx_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .qstat    (qstat),
        .cmd      (head_cmd),
        .pop      (pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .res      (res)
    );

    assign m_tdata = {4'b0000, res.status, res.payload_len, res.payload_write,
                      res.ack_block, res.ack_port};
    assign m_tuser = res.action;

endmodule

// ===== hw/rtl/tftprx_checker.sv =====
// ----------------------------------------------------------------------------
// tftprx_checker
// Port-level checks on the result stream of the receive sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tftprx_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [tftprx_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [1:0]                          m_tuser
);
    import tftprx_pkg::*;

    // stalled result word holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // a read request always restarts with status running and block zero
    `ASSERT_NOW(a_rrq_run, clk, rst_n, m_tvalid && m_tuser == ACT_RRQ,
        m_tdata[51:49] == PH_RUN && m_tdata[31:16] == 16'd0)

    // payload only goes with an acknowledgement
    `ASSERT_NOW(a_pw_ack, clk, rst_n, m_tvalid && m_tdata[32],
        m_tuser == ACT_ACK)

    // no action: ack and payload fields zero
    `ASSERT_NOW(a_none_zero, clk, rst_n, m_tvalid && m_tuser == ACT_NONE,
        m_tdata[48:0] == 49'd0)

    // a full block keeps the transfer running
    `ASSERT_NOW(a_full_run, clk, rst_n,
        m_tvalid && m_tdata[32] && m_tdata[48:33] >= BLOCK_BYTES,
        m_tdata[51:49] == PH_RUN)

endmodule

bind tftp_receive_block_sequencer_unit tftprx_checker u_tftprx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
